[hw/rtl/tracked_object_table_unit_defines.svh]
// Assertion macros shared by the tracked object table RTL.
`ifndef TRACKED_OBJECT_TABLE_UNIT_DEFINES_SVH
`define TRACKED_OBJECT_TABLE_UNIT_DEFINES_SVH

// Check that an expression holds at every clock edge outside reset.
`define TOT_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("tracked object table check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define TOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tracked object table sequence check failed");

`endif

[hw/rtl/tot_pkg.sv]
// Shared types, constants and codes for the tracked object table.
`timescale 1ns / 1ps
`default_nettype none
package tot_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 24;
    localparam int TIME_W    = 32;
    localparam int DIST_W    = 16;
    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [TIME_W-1:0] STALE_LIMIT_RST = 32'd60000;
    localparam logic [DIST_W-1:0] RANGE_LIMIT_RST = 16'd1600;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 1'b1;

    // Operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PURGE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 3'd0,
        ST_EXISTING = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_STALE    = 3'd3,
        ST_EVICTED  = 3'd4,
        ST_PURGED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One table entry as it travels round the ring
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_seen;
        logic              has_dist;
        logic [DIST_W-1:0] distance;
    } t_entry;

    // Write left over from the previous item, applied as its slot passes the head
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_pend;

    // What one pass round the ring has gathered
    typedef struct packed {
        logic [CNT_W-1:0]  total_act;
        logic [CNT_W-1:0]  total_rng;
        logic              match_found;
        logic [IDX_W-1:0]  match_idx;
        logic              match_act;
        logic              match_rng;
        logic              match_hasd;
        logic [DIST_W-1:0] match_dist;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              free_stale;
        logic [IDX_W-1:0]  old_idx;
        logic              old_rng;
    } t_scan_sum;

endpackage
`default_nettype wire

[hw/rtl/tot_cell.sv]
// One ring cell: holds a table entry and passes it on while the ring turns.
`timescale 1ns / 1ps
`default_nettype none
module tot_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire tot_pkg::t_entry i_entry,
    output tot_pkg::t_entry      o_entry
);
    import tot_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_last_seen;
    logic              r_has_dist;
    logic [DIST_W-1:0] r_dist;

    // Valid bit: cleared by reset, table starts empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    // Entry payload: advance with the ring
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key       <= i_entry.key;
            r_last_seen <= i_entry.last_seen;
            r_has_dist  <= i_entry.has_dist;
            r_dist      <= i_entry.distance;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, last_seen: r_last_seen,
                       has_dist: r_has_dist, distance: r_dist};
endmodule
`default_nettype wire

[hw/rtl/tot_head.sv]
// Ring head: applies pending writes and purges, and gathers match, slot and counts.
`timescale 1ns / 1ps
`default_nettype none
module tot_head (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_scan,
    input  wire logic [tot_pkg::IDX_W-1:0]   i_idx,
    input  wire tot_pkg::t_entry             i_head,
    input  wire tot_pkg::t_pend              i_pend,
    input  wire logic                        i_purge,
    input  wire logic [tot_pkg::KEY_W-1:0]   i_key,
    input  wire logic [tot_pkg::TIME_W-1:0]  i_now,
    input  wire logic [tot_pkg::TIME_W-1:0]  i_stale_limit,
    input  wire logic [tot_pkg::DIST_W-1:0]  i_range_limit,
    output tot_pkg::t_entry                  o_feed,
    output tot_pkg::t_scan_sum               o_sum
);
    import tot_pkg::*;

    t_entry            eff;
    logic [TIME_W-1:0] age;
    logic              stale;
    logic              near;
    logic              act;
    logic              rng;
    logic              is_match;
    logic              is_free;

    logic [CNT_W-1:0]  r_total_act;
    logic [CNT_W-1:0]  r_total_rng;
    logic              r_match_found;
    logic              r_free_found;
    logic              r_old_have;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_match_act;
    logic              r_match_rng;
    logic              r_match_hasd;
    logic [DIST_W-1:0] r_match_dist;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_free_stale;
    logic [IDX_W-1:0]  r_old_idx;
    logic [TIME_W-1:0] r_old_age;
    logic              r_old_rng;

    // Examine the entry at the head after the pending write and any purge
    always_comb begin
        eff = i_head;
        if (i_pend.valid && (i_pend.idx == i_idx)) begin
            eff = i_pend.entry;
        end
        age   = i_now - eff.last_seen;
        stale = age > i_stale_limit;
        if (i_purge && eff.valid && stale) begin
            eff.valid = 1'b0;
        end
        near     = eff.has_dist && (eff.distance <= i_range_limit);
        act      = eff.valid && !stale;
        rng      = act && near;
        is_match = eff.valid && (eff.key == i_key);
        is_free  = !eff.valid || stale;
    end

    assign o_feed = eff;

    // Flags and counts: clear on start, gather while the ring turns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_act   <= '0;
            r_total_rng   <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_old_have    <= 1'b0;
        end else if (i_start) begin
            r_total_act   <= '0;
            r_total_rng   <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_old_have    <= 1'b0;
        end else if (i_scan) begin
            r_total_act <= r_total_act + CNT_W'(act);
            r_total_rng <= r_total_rng + CNT_W'(rng);
            if (!r_match_found && is_match) begin
                r_match_found <= 1'b1;
            end
            if (!r_free_found && is_free) begin
                r_free_found <= 1'b1;
            end
            if (eff.valid && (!r_old_have || (age > r_old_age))) begin
                r_old_have <= 1'b1;
            end
        end
    end

    // Candidate details: hold the first match, first free slot and oldest entry
    always_ff @(posedge i_clk) begin
        if (i_scan && !i_start) begin
            if (!r_match_found && is_match) begin
                r_match_idx  <= i_idx;
                r_match_act  <= act;
                r_match_rng  <= rng;
                r_match_hasd <= eff.has_dist;
                r_match_dist <= eff.distance;
            end
            if (!r_free_found && is_free) begin
                r_free_idx   <= i_idx;
                r_free_stale <= eff.valid;
            end
            if (eff.valid && (!r_old_have || (age > r_old_age))) begin
                r_old_idx <= i_idx;
                r_old_age <= age;
                r_old_rng <= rng;
            end
        end
    end

    assign o_sum = '{total_act:   r_total_act,
                     total_rng:   r_total_rng,
                     match_found: r_match_found,
                     match_idx:   r_match_idx,
                     match_act:   r_match_act,
                     match_rng:   r_match_rng,
                     match_hasd:  r_match_hasd,
                     match_dist:  r_match_dist,
                     free_found:  r_free_found,
                     free_idx:    r_free_idx,
                     free_stale:  r_free_stale,
                     old_idx:     r_old_idx,
                     old_rng:     r_old_rng};
endmodule
`default_nettype wire

[hw/rtl/tracked_object_table_unit.sv]
// The entry ring turns once per item past a single head that examines one entry a cycle;
// the input stalls while an item's pass is in progress, so a new item waits for it to end.
// A table write found by one item is applied as that slot passes the head in the next.
// Reset (synchronous, active low) empties the table at once and restores the
// stale and range limits to 60000 ms and 100 nmi; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "tracked_object_table_unit_defines.svh"
module tracked_object_table_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [tot_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tot_pkg::CFG_W-1:0]      i_cfg_data,
    // input item channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [tot_pkg::KEY_W-1:0]      i_target_key,
    input  wire logic [tot_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic                           i_observed,
    input  wire logic                           i_distance_valid,
    input  wire logic [tot_pkg::DIST_W-1:0]     i_distance,
    // result item channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [tot_pkg::SLOT_W-1:0]          o_slot,
    output logic [tot_pkg::STATUS_W-1:0]        o_status,
    output logic [tot_pkg::OCC_W-1:0]           o_active_count,
    output logic [tot_pkg::OCC_W-1:0]           o_in_range_count
);
    import tot_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state;
    t_state n_state;
    logic   start;
    logic   scan;
    logic   finish;

    logic [TIME_W-1:0] r_stale_limit;
    logic [DIST_W-1:0] r_range_limit;

    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic              r_obs;
    logic              r_dist_ok;
    logic [DIST_W-1:0] r_dist;
    logic [IDX_W-1:0]  r_idx;

    logic              r_pend_valid;
    logic [IDX_W-1:0]  r_pend_idx;
    t_entry            r_pend_entry;
    logic              n_pend_valid;
    logic [IDX_W-1:0]  n_pend_idx;
    t_entry            n_pend_entry;
    t_pend             pend;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_slot;
    t_status           r_status;
    logic [CNT_W-1:0]  r_active;
    logic [CNT_W-1:0]  r_in_range;
    logic [IDX_W-1:0]  n_slot;
    t_status           n_status;
    logic [CNT_W-1:0]  n_active;
    logic [CNT_W-1:0]  n_in_range;

    t_entry            ring [ENTRIES];
    t_entry            feed;
    t_scan_sum         sum;

    logic              obs;
    logic              new_hasd;
    logic [DIST_W-1:0] new_dist;
    logic              new_rng;

    // Configuration registers: the user must see that they are written only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RST;
            r_range_limit <= RANGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STALE_LIMIT: r_stale_limit <= i_cfg_data;
                CFG_RANGE_LIMIT: r_range_limit <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: take an item, turn the ring once, then publish the result
    always_comb begin
        n_state = r_state;
        start   = 1'b0;
        scan    = 1'b0;
        finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    start   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                scan = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Item registers and head index
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op      <= i_operation;
            r_key     <= i_target_key;
            r_now     <= i_now_ms;
            r_obs     <= i_observed;
            r_dist_ok <= i_distance_valid;
            r_dist    <= i_distance;
            r_idx     <= '0;
        end else if (scan) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Ring of entry cells: each hands its entry to the one before it
    for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
        if (g == ENTRIES - 1) begin : g_tail
            tot_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (scan),
                .i_entry (feed),
                .o_entry (ring[g])
            );
        end else begin : g_body
            tot_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (scan),
                .i_entry (ring[g+1]),
                .o_entry (ring[g])
            );
        end
    end

    assign pend = '{valid: r_pend_valid, idx: r_pend_idx, entry: r_pend_entry};

    tot_head u_head (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_scan        (scan),
        .i_idx         (r_idx),
        .i_head        (ring[0]),
        .i_pend        (pend),
        .i_purge       (r_op == OP_PURGE),
        .i_key         (r_key),
        .i_now         (r_now),
        .i_stale_limit (r_stale_limit),
        .i_range_limit (r_range_limit),
        .o_feed        (feed),
        .o_sum         (sum)
    );

    // Resolve the slot, status, counts and the write left for the next pass
    always_comb begin
        obs      = r_obs || r_dist_ok;
        new_hasd = r_dist_ok;
        new_dist = r_dist_ok ? r_dist : '0;
        if (sum.match_found) begin
            new_hasd = r_dist_ok || sum.match_hasd;
            new_dist = r_dist_ok ? r_dist : sum.match_dist;
        end
        new_rng = new_hasd && (new_dist <= r_range_limit);

        n_slot       = '0;
        n_status     = ST_IGNORED;
        n_active     = sum.total_act;
        n_in_range   = sum.total_rng;
        n_pend_valid = 1'b0;
        n_pend_idx   = '0;
        n_pend_entry = '{valid: 1'b1, key: r_key, last_seen: r_now,
                         has_dist: new_hasd, distance: new_dist};

        if (r_op == OP_PURGE) begin
            n_status = ST_PURGED;
        end else if (sum.match_found) begin
            n_slot   = sum.match_idx;
            n_status = ST_EXISTING;
            if (obs) begin
                n_pend_valid = 1'b1;
                n_pend_idx   = sum.match_idx;
                n_active     = sum.total_act - CNT_W'(sum.match_act) + CNT_W'(1);
                n_in_range   = sum.total_rng - CNT_W'(sum.match_rng) + CNT_W'(new_rng);
            end
        end else if (obs) begin
            n_pend_valid = 1'b1;
            if (sum.free_found) begin
                n_slot     = sum.free_idx;
                n_status   = sum.free_stale ? ST_STALE : ST_EMPTY;
                n_active   = sum.total_act + CNT_W'(1);
                n_in_range = sum.total_rng + CNT_W'(new_rng);
            end else begin
                n_slot     = sum.old_idx;
                n_status   = ST_EVICTED;
                n_in_range = sum.total_rng - CNT_W'(sum.old_rng) + CNT_W'(new_rng);
            end
            n_pend_idx = n_slot;
        end
    end

    // Pending write: replace at the end of every pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (finish) begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_pend_idx   <= n_pend_idx;
            r_pend_entry <= n_pend_entry;
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_slot     <= n_slot;
            r_status   <= n_status;
            r_active   <= n_active;
            r_in_range <= n_in_range;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_slot           = SLOT_W'(r_slot);
    assign o_status         = r_status;
    assign o_active_count   = OCC_W'(r_active);
    assign o_in_range_count = OCC_W'(r_in_range);

    // Checks on the sequencer and the pending write
    `TOT_ASSERT_NEXT(a_accept_starts_pass, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_SCAN && r_idx == '0)
    `TOT_ASSERT_NEXT(a_pend_held_in_pass, i_clk, i_rst_n, r_state == S_SCAN, $stable(r_pend_valid))
    `TOT_ASSERT_HOLDS(a_result_after_pass, i_clk, i_rst_n, !$rose(r_out_valid) || $past(r_state) == S_DONE)

endmodule
`default_nettype wire
